@@ rtl/aes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and round functions for AES-128 CBC
// S-box, round constants, payload structs and controller/datapath commands.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NumRounds = 10;
	localparam int RndW = 4;
	localparam int AddrW = 5;

	localparam logic [AddrW-1:0] RegKeyHigh = 5'h00;
	localparam logic [AddrW-1:0] RegKeyLow  = 5'h08;
	localparam logic [AddrW-1:0] RegIvHigh  = 5'h10;
	localparam logic [AddrW-1:0] RegIvLow   = 5'h18;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
		logic        restart;
	} in_item_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic            load;     // take the input block, add round key 0
		logic            round;    // one cipher round
		logic            last;     // round without MixColumns
		logic            key_init; // restart key schedule from key regs
		logic            key_step; // advance key schedule by one round
		logic            commit;   // store cipher as chain value
	} dp_cmd_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] rcon(input logic [RndW-1:0] r);
		logic [7:0] v;
		unique case (r)
			4'd0: v = 8'h01;
			4'd1: v = 8'h02;
			4'd2: v = 8'h04;
			4'd3: v = 8'h08;
			4'd4: v = 8'h10;
			4'd5: v = 8'h20;
			4'd6: v = 8'h40;
			4'd7: v = 8'h80;
			4'd8: v = 8'h1b;
			4'd9: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte k sits at bits [127-8k -: 8]
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic logic [127:0] next_key(input logic [127:0] k,
		input logic [RndW-1:0] r);
		logic [31:0] t, w0, w1, w2, w3;
		t = {sbox(k[23:16]) ^ rcon(r), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

@@ rtl/aes_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctrl: block sequencer
// Accepts a block, steps ten rounds, holds the result until taken.
// ----------------------------------------------------------------------------
module aes_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output aes_pkg::dp_cmd_t cmd
);
	import aes_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;
	localparam logic [1:0] StDone = 2'd2;

	logic [1:0]      state_q;
	logic [RndW-1:0] rnd_q;

	// result register lives in datapath; a new block may start once it is taken
	assign in_ready  = (state_q == StIdle) || (state_q == StDone && out_ready);
	assign out_valid = (state_q == StDone);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && in_ready;
		cmd.key_init = cmd.load;
		cmd.round    = (state_q == StRun);
		cmd.last     = (state_q == StRun) && (rnd_q == RndW'(NumRounds - 1));
		cmd.key_step = (state_q == StRun);
		cmd.commit   = cmd.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (cmd.load) begin
						state_q <= StRun;
						rnd_q   <= '0;
					end
				end
				StRun: begin
					rnd_q <= rnd_q + 1'b1;
					if (cmd.last) state_q <= StDone;
				end
				StDone: begin
					if (cmd.load) begin
						state_q <= StRun;
						rnd_q   <= '0;
					end else if (out_ready) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> out_valid)
		else $error("result not presented after last round");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StRun) |-> !in_ready)
		else $error("input taken mid-block");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");
endmodule

@@ rtl/aes_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_dp: AES-128 round datapath
// State register, on-the-fly key schedule, chain value and config registers.
// ----------------------------------------------------------------------------
module aes_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  aes_pkg::dp_cmd_t  cmd,
	input  aes_pkg::in_item_t in_data,
	output aes_pkg::out_item_t out_data,
	input  logic              cfg_we,
	input  logic [aes_pkg::AddrW-1:0] cfg_addr,
	input  logic [63:0]       cfg_wdata,
	output logic [63:0]       cfg_rdata
);
	import aes_pkg::*;

	logic [127:0]    key_q, iv_q, chain_q, state_q, rk_q;
	logic [RndW-1:0] krnd_q;
	logic [127:0]    chain_sel, blk, nk, ss;

	assign chain_sel = in_data.restart ? iv_q : chain_q;
	assign blk = {in_data.plain_high, in_data.plain_low} ^ chain_sel ^ key_q;
	assign nk  = next_key(rk_q, krnd_q);
	assign ss  = sub_shift(state_q);
	assign out_data = {state_q[127:64], state_q[63:0]};

	always_comb begin
		unique case (cfg_addr)
			RegKeyHigh: cfg_rdata = key_q[127:64];
			RegKeyLow:  cfg_rdata = key_q[63:0];
			RegIvHigh:  cfg_rdata = iv_q[127:64];
			RegIvLow:   cfg_rdata = iv_q[63:0];
			default:    cfg_rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			iv_q    <= '0;
			chain_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					RegKeyHigh: key_q[127:64] <= cfg_wdata;
					RegKeyLow:  key_q[63:0]   <= cfg_wdata;
					RegIvHigh:  iv_q[127:64]  <= cfg_wdata;
					RegIvLow:   iv_q[63:0]    <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.commit) chain_q <= ss ^ nk;
		end
	end

	// round keys are generated one per round alongside the state
	always_ff @(posedge clk) begin
		if (cmd.load) state_q <= blk;
		else if (cmd.round) state_q <= (cmd.last ? ss : mix_columns(ss)) ^ nk;
		if (cmd.key_init) begin
			rk_q   <= key_q;
			krnd_q <= '0;
		end else if (cmd.key_step) begin
			rk_q   <= nk;
			krnd_q <= krnd_q + 1'b1;
		end
	end
endmodule

@@ rtl/aes128_cbc_encrypt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_encrypt: AES-128 CBC encryption core
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data  (plain_high, plain_low, restart)
// out     | out | out_valid/out_ready | out_data (cipher_high, cipher_low)
// cfg     | in  | APB psel/penable    | key_high, key_low, iv_high, iv_low
// A block is processed in steps: the transfer cycle adds round key 0, then ten
// rounds on one round unit, with keys derived on the fly each round.
// The result is held until transferred; the next block may be taken in the
// same cycle. Reset clears key, IV and chain value; no clearing pass.
// ----------------------------------------------------------------------------
module aes128_cbc_encrypt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aes_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output aes_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [aes_pkg::AddrW-1:0] paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import aes_pkg::*;

	dp_cmd_t cmd;

	assign pready = 1'b1;

	aes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd)
	);

	aes_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_data(in_data), .out_data(out_data),
		.cfg_we(psel && penable && pwrite), .cfg_addr(paddr),
		.cfg_wdata(pwdata), .cfg_rdata(prdata)
	);
endmodule
